// ===== src/tsae_pkg.sv =====
// Shared types and codes for the two-set algebra engine.
// Holds the command and result word layouts and the mode and status codes.
// No dependencies.
package tsae_pkg;

    typedef logic signed [31:0] t_elem;

    typedef struct packed {
        logic [2:0] mode;
        t_elem      value;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        t_elem      element;
        logic       last;
    } t_res;

    localparam logic [2:0] MODE_INS_A     = 3'd0;
    localparam logic [2:0] MODE_INS_B     = 3'd1;
    localparam logic [2:0] MODE_CLEAR     = 3'd2;
    localparam logic [2:0] MODE_DISJOINT  = 3'd3;
    localparam logic [2:0] MODE_UNION     = 3'd4;
    localparam logic [2:0] MODE_INTERSECT = 3'd5;
    localparam logic [2:0] MODE_A_MINUS_B = 3'd6;
    localparam logic [2:0] MODE_B_MINUS_A = 3'd7;

    localparam logic [2:0] ST_ELEMENT      = 3'd0;
    localparam logic [2:0] ST_INSERTED     = 3'd1;
    localparam logic [2:0] ST_DUPLICATE    = 3'd2;
    localparam logic [2:0] ST_FULL         = 3'd3;
    localparam logic [2:0] ST_DISJOINT     = 3'd4;
    localparam logic [2:0] ST_NOT_DISJOINT = 3'd5;
    localparam logic [2:0] ST_EMPTY        = 3'd6;

    localparam int MAX_RESULTS = 16;

endpackage

// ===== src/tsae_match.sv =====
// Membership compare unit: checks one candidate against the valid entries of a set.
// Depends on tsae_pkg for the element type.
module tsae_match import tsae_pkg::*; #(
    parameter int SET_CAPACITY = 8,
    localparam int CW = $clog2(SET_CAPACITY + 1)
) (
    input  t_elem                    i_cand,
    input  t_elem [SET_CAPACITY-1:0] i_set,
    input  logic  [CW-1:0]           i_count,
    output logic                     o_hit
);

    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < SET_CAPACITY; k++) begin
            if ((CW'(k) < i_count) && (i_set[k] == i_cand)) begin
                o_hit = 1'b1;
            end
        end
    end

endmodule

// ===== src/two_set_algebra_engine_unit.sv =====
// Two-set algebra engine: insert, clear, disjoint query, union, intersection, differences.
// Insert: busy in the insert state, then one result. Clear: taken in the accept cycle, no result.
// Query and set commands: busy while scanning, one candidate compared per cycle by the
// match unit; union passes over all of A, then over B.
// Results leave at most one a cycle and cannot be stalled.
// Synchronous reset empties both sets; stored entries are not cleared. Uses tsae_pkg, tsae_match.
module two_set_algebra_engine_unit import tsae_pkg::*; #(
    parameter int SET_CAPACITY = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int RW = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    t_elem [SET_CAPACITY-1:0] r_set_a;
    t_elem [SET_CAPACITY-1:0] r_set_b;

    logic [1:0]    r_state, n_state;
    logic [2:0]    r_mode, n_mode;
    t_elem         r_value, n_value;
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_src_b, n_src_b;
    logic          r_keep, n_keep;
    logic          r_all, n_all;
    logic          r_pend_v, n_pend_v;
    t_elem         r_pend, n_pend;
    logic [RW-1:0] r_nres, n_nres;
    logic          r_strobe, n_strobe;
    t_res          r_res, n_res;

    logic          w_wr_a, w_wr_b;
    t_elem         w_cand;
    t_elem [SET_CAPACITY-1:0] w_mset;
    logic [CW-1:0] w_mcnt;
    logic          w_hit;
    t_elem         w_src_elem;
    logic [CW-1:0] w_src_cnt;
    logic          w_ins_b;
    logic          w_keep_it;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    assign w_ins_b    = (r_mode == MODE_INS_B);
    assign w_src_elem = r_src_b ? r_set_b[r_idx[IW-1:0]] : r_set_a[r_idx[IW-1:0]];
    assign w_src_cnt  = r_src_b ? r_cnt_b : r_cnt_a;

    // Route the compare unit: insert checks the target set, a scan checks the other set.
    always_comb begin
        if (r_state == S_INS) begin
            w_cand = r_value;
            w_mset = w_ins_b ? r_set_b : r_set_a;
            w_mcnt = w_ins_b ? r_cnt_b : r_cnt_a;
        end else begin
            w_cand = w_src_elem;
            w_mset = r_src_b ? r_set_a : r_set_b;
            w_mcnt = r_src_b ? r_cnt_a : r_cnt_b;
        end
    end

    tsae_match #(
        .SET_CAPACITY(SET_CAPACITY)
    ) u_match (
        .i_cand  (w_cand),
        .i_set   (w_mset),
        .i_count (w_mcnt),
        .o_hit   (w_hit)
    );

    assign w_keep_it = r_all || (w_hit == r_keep);

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_value  = r_value;
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_idx    = r_idx;
        n_src_b  = r_src_b;
        n_keep   = r_keep;
        n_all    = r_all;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_nres   = r_nres;
        n_strobe = 1'b0;
        n_res    = r_res;
        w_wr_a   = 1'b0;
        w_wr_b   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode   = i_cmd.mode;
                    n_value  = i_cmd.value;
                    n_idx    = '0;
                    n_pend_v = 1'b0;
                    n_nres   = '0;
                    n_src_b  = (i_cmd.mode == MODE_B_MINUS_A);
                    n_keep   = (i_cmd.mode == MODE_DISJOINT) || (i_cmd.mode == MODE_INTERSECT);
                    n_all    = (i_cmd.mode == MODE_UNION);
                    unique case (i_cmd.mode)
                        MODE_INS_A, MODE_INS_B: n_state = S_INS;
                        MODE_CLEAR: begin
                            n_cnt_a = '0;
                            n_cnt_b = '0;
                        end
                        default: n_state = S_SCAN;
                    endcase
                end
            end
            S_INS: begin
                n_strobe        = 1'b1;
                n_res.element   = '0;
                n_res.last      = 1'b1;
                n_state         = S_IDLE;
                if (w_hit) begin
                    n_res.status = ST_DUPLICATE;
                end else if (w_mcnt == CW'(SET_CAPACITY)) begin
                    n_res.status = ST_FULL;
                end else begin
                    n_res.status = ST_INSERTED;
                    if (w_ins_b) begin
                        w_wr_b  = 1'b1;
                        n_cnt_b = r_cnt_b + CW'(1);
                    end else begin
                        w_wr_a  = 1'b1;
                        n_cnt_a = r_cnt_a + CW'(1);
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == w_src_cnt) begin
                    // union: after all of A, pass over B keeping what A lacks
                    if (r_all) begin
                        n_all   = 1'b0;
                        n_keep  = 1'b0;
                        n_src_b = 1'b1;
                        n_idx   = '0;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                    if (w_keep_it) begin
                        if (r_mode == MODE_DISJOINT) begin
                            n_strobe      = 1'b1;
                            n_res.status  = ST_NOT_DISJOINT;
                            n_res.element = w_src_elem;
                            n_res.last    = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            // hold one element back so the final one can carry last
                            if (r_pend_v) begin
                                n_strobe      = 1'b1;
                                n_res.status  = ST_ELEMENT;
                                n_res.element = r_pend;
                                n_res.last    = 1'b0;
                            end
                            n_pend_v = 1'b1;
                            n_pend   = w_src_elem;
                            n_nres   = r_nres + RW'(1);
                            if (r_nres == RW'(MAX_RESULTS - 1)) begin
                                n_state = S_FIN;
                            end
                        end
                    end
                end
            end
            S_FIN: begin
                n_strobe   = 1'b1;
                n_res.last = 1'b1;
                n_state    = S_IDLE;
                if (r_mode == MODE_DISJOINT) begin
                    n_res.status  = ST_DISJOINT;
                    n_res.element = '0;
                end else if (r_pend_v) begin
                    n_res.status  = ST_ELEMENT;
                    n_res.element = r_pend;
                end else begin
                    n_res.status  = ST_EMPTY;
                    n_res.element = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Set storage, written only by an accepted insert.
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_set_a[r_cnt_a[IW-1:0]] <= r_value;
        end
        if (w_wr_b) begin
            r_set_b[r_cnt_b[IW-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_strobe <= 1'b0;
            r_pend_v <= 1'b0;
            r_idx    <= '0;
            r_nres   <= '0;
            r_src_b  <= 1'b0;
            r_keep   <= 1'b0;
            r_all    <= 1'b0;
            r_mode   <= MODE_INS_A;
        end else begin
            r_state  <= n_state;
            r_cnt_a  <= n_cnt_a;
            r_cnt_b  <= n_cnt_b;
            r_strobe <= n_strobe;
            r_pend_v <= n_pend_v;
            r_idx    <= n_idx;
            r_nres   <= n_nres;
            r_src_b  <= n_src_b;
            r_keep   <= n_keep;
            r_all    <= n_all;
            r_mode   <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pend  <= n_pend;
        r_res   <= n_res;
    end

endmodule
